@@ design/ppc_pkg.sv @@
`timescale 1ns / 1ps
package ppc_pkg;

	localparam logic [27:0] STEP_PRIMORIAL = 28'd223092870;
	localparam logic [63:0] FULL_LIMIT = 64'd3825123056546413051;

	localparam logic [3:0] CMD_NOP       = 4'd0;
	localparam logic [3:0] CMD_LOAD      = 4'd1;
	localparam logic [3:0] CMD_SW_START  = 4'd2;
	localparam logic [3:0] CMD_SW_STEP   = 4'd3;
	localparam logic [3:0] CMD_SW_FIN    = 4'd4;
	localparam logic [3:0] CMD_R2_INIT   = 4'd5;
	localparam logic [3:0] CMD_DBL_CMP   = 4'd6;
	localparam logic [3:0] CMD_DBL_APPLY = 4'd7;
	localparam logic [3:0] CMD_EXP_INIT  = 4'd8;
	localparam logic [3:0] CMD_EXP_DEC   = 4'd9;
	localparam logic [3:0] CMD_S_INIT    = 4'd10;
	localparam logic [3:0] CMD_S_INC     = 4'd11;
	localparam logic [3:0] CMD_NEXT_BASE = 4'd12;
	localparam logic [3:0] CMD_TERM_NEXT = 4'd13;
	localparam logic [3:0] CMD_DONE      = 4'd14;

	localparam logic [1:0] MS_R2SQ = 2'd0;
	localparam logic [1:0] MS_BASE = 2'd1;
	localparam logic [1:0] MS_ASQ  = 2'd2;
	localparam logic [1:0] MS_AMB  = 2'd3;

	typedef struct packed {
		logic        operation;
		logic [5:0]  term_count;
		logic [30:0] difference;
		logic [63:0] initial_term;
	} req_t;

	typedef struct packed {
		logic [5:0] first_bad_index;
		logic       all_passed;
	} rsp_t;

	typedef struct packed {
		logic [3:0] code;
		logic       mont_start;
		logic [1:0] msel;
	} cmd_t;

	typedef struct packed {
		logic n_even;
		logic n_is_one;
		logic idx_done;
		logic sweep_last;
		logic exp_more;
		logic exp_bit;
		logic s_more;
		logic a_is_one;
		logic a_is_m1;
		logic base_last;
		logic mont_done;
	} sts_t;

	function automatic logic [5:0] prime_base(input logic [3:0] idx);
		logic [5:0] b;
		case (idx)
			4'd0: b = 6'd2;
			4'd1: b = 6'd3;
			4'd2: b = 6'd5;
			4'd3: b = 6'd7;
			4'd4: b = 6'd11;
			4'd5: b = 6'd13;
			4'd6: b = 6'd17;
			4'd7: b = 6'd19;
			4'd8: b = 6'd23;
			4'd9: b = 6'd29;
			4'd10: b = 6'd31;
			4'd11: b = 6'd37;
			default: b = 6'd2;
		endcase
		return b;
	endfunction

endpackage

@@ design/ppc_mont.sv @@
`timescale 1ns / 1ps
module ppc_mont (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [63:0] n,
	input  logic [63:0] qinv,
	output logic        done,
	output logic [63:0] res
);
	logic [3:0]   step_q;
	logic         busy_q;
	logic         done_q;
	logic [127:0] acc_q;
	logic [63:0]  m_q;
	logic [63:0]  hi_q;
	logic [63:0]  diff_q;
	logic         bor_q;
	logic [63:0]  res_q;
	logic [31:0]  mx;
	logic [31:0]  my;
	logic [63:0]  pp;
	logic [127:0] addend;

	always_comb begin
		case (step_q)
			4'd0: begin mx = a[31:0]; my = b[31:0]; end
			4'd1: begin mx = a[31:0]; my = b[63:32]; end
			4'd2: begin mx = a[63:32]; my = b[31:0]; end
			4'd3: begin mx = a[63:32]; my = b[63:32]; end
			4'd4: begin mx = acc_q[31:0]; my = qinv[31:0]; end
			4'd5: begin mx = acc_q[31:0]; my = qinv[63:32]; end
			4'd6: begin mx = acc_q[63:32]; my = qinv[31:0]; end
			4'd7: begin mx = m_q[31:0]; my = n[31:0]; end
			4'd8: begin mx = m_q[31:0]; my = n[63:32]; end
			4'd9: begin mx = m_q[63:32]; my = n[31:0]; end
			4'd10: begin mx = m_q[63:32]; my = n[63:32]; end
			default: begin mx = 32'd0; my = 32'd0; end
		endcase
	end

	assign pp = mx * my;

	always_comb begin
		case (step_q)
			4'd1, 4'd2, 4'd8, 4'd9: addend = {32'd0, pp, 32'd0};
			4'd3, 4'd10: addend = {pp, 64'd0};
			default: addend = {64'd0, pp};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 4'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 4'd0;
			end else if (busy_q) begin
				if (step_q == 4'd12) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			case (step_q)
				4'd0, 4'd7: acc_q <= {64'd0, pp};
				4'd1, 4'd2, 4'd3, 4'd8, 4'd9, 4'd10: acc_q <= acc_q + addend;
				4'd4: begin
					hi_q <= acc_q[127:64];
					m_q <= pp;
				end
				4'd5, 4'd6: m_q <= m_q + {pp[31:0], 32'd0};
				4'd11: begin
					diff_q <= hi_q - acc_q[127:64];
					bor_q <= hi_q < acc_q[127:64];
				end
				4'd12: res_q <= bor_q ? diff_q + n : diff_q;
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign res = res_q;
endmodule

@@ design/ppc_datapath.sv @@
`timescale 1ns / 1ps
module ppc_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  ppc_pkg::cmd_t cmd,
	input  ppc_pkg::req_t req,
	output ppc_pkg::sts_t sts,
	output ppc_pkg::rsp_t rsp
);
	import ppc_pkg::*;

	logic        op_q;
	logic [5:0]  count_q;
	logic [63:0] n_q;
	logic [63:0] stride_q;
	logic [5:0]  idx_q;
	logic [63:0] nm1_q;
	logic [63:0] dvd_q;
	logic [5:0]  i_q;
	logic [63:0] u_q;
	logic [63:0] qinv_q;
	logic [63:0] rem_q;
	logic        found_q;
	logic [5:0]  tz_q;
	logic [5:0]  hib_q;
	logic [63:0] one_q;
	logic [63:0] m1_q;
	logic [5:0]  t_q;
	logic [63:0] r2_q;
	logic        cmp_q;
	logic [63:0] mb_q;
	logic [63:0] a_q;
	logic [3:0]  base_q;
	logic [5:0]  k_q;
	logic [5:0]  s_q;
	logic [1:0]  msel_q;
	rsp_t        rsp_q;

	logic [64:0] rem_sh;
	logic [64:0] rem_sub;
	logic [63:0] u_new;
	logic [63:0] mont_a;
	logic [63:0] mont_b;
	logic [63:0] mont_res;
	logic        mont_done;
	logic [3:0]  base_cnt;
	logic [58:0] stride;

	assign stride = req.difference * STEP_PRIMORIAL;
	assign rem_sh = {rem_q, dvd_q[~i_q]};
	assign rem_sub = rem_sh - {1'b0, n_q};
	assign u_new = u_q[0] ? u_q - n_q : u_q;

	always_comb begin
		case (msel_q)
			MS_R2SQ: begin mont_a = r2_q; mont_b = r2_q; end
			MS_BASE: begin mont_a = {58'd0, prime_base(base_q)}; mont_b = r2_q; end
			MS_ASQ: begin mont_a = a_q; mont_b = a_q; end
			default: begin mont_a = a_q; mont_b = mb_q; end
		endcase
	end

	ppc_mont u_mont (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.mont_start),
		.a(mont_a),
		.b(mont_b),
		.n(n_q),
		.qinv(qinv_q),
		.done(mont_done),
		.res(mont_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.mont_start) begin
			msel_q <= cmd.msel;
		end
		if (mont_done) begin
			case (msel_q)
				MS_R2SQ: r2_q <= mont_res;
				MS_BASE: begin
					mb_q <= mont_res;
					a_q <= mont_res;
				end
				default: a_q <= mont_res;
			endcase
		end
		case (cmd.code)
			CMD_LOAD: begin
				op_q <= req.operation;
				count_q <= req.term_count;
				n_q <= req.initial_term;
				stride_q <= {5'd0, stride};
				idx_q <= 6'd0;
			end
			CMD_SW_START: begin
				nm1_q <= n_q - 64'd1;
				dvd_q <= 64'd0 - n_q;
				i_q <= 6'd0;
				u_q <= 64'd1;
				qinv_q <= 64'd0;
				rem_q <= 64'd0;
				found_q <= 1'b0;
				tz_q <= 6'd0;
				hib_q <= 6'd0;
			end
			CMD_SW_STEP: begin
				if (nm1_q[i_q]) begin
					hib_q <= i_q;
					if (!found_q && i_q != 6'd63) begin
						found_q <= 1'b1;
						tz_q <= i_q;
					end
				end
				rem_q <= rem_sub[64] ? rem_sh[63:0] : rem_sub[63:0];
				qinv_q <= {u_q[0], qinv_q[63:1]};
				u_q <= {1'b0, u_new[63:1]};
				i_q <= i_q + 6'd1;
			end
			CMD_SW_FIN: begin
				one_q <= rem_q;
				t_q <= found_q ? tz_q : 6'd63;
			end
			CMD_R2_INIT: begin
				r2_q <= one_q;
				m1_q <= n_q - one_q;
				base_q <= 4'd0;
			end
			CMD_DBL_CMP: cmp_q <= r2_q >= n_q - r2_q;
			CMD_DBL_APPLY: r2_q <= r2_q + r2_q - (cmp_q ? n_q : 64'd0);
			CMD_EXP_INIT: k_q <= hib_q - 6'd1;
			CMD_EXP_DEC: k_q <= k_q - 6'd1;
			CMD_S_INIT: s_q <= 6'd1;
			CMD_S_INC: s_q <= s_q + 6'd1;
			CMD_NEXT_BASE: base_q <= base_q + 4'd1;
			CMD_TERM_NEXT: begin
				n_q <= n_q + stride_q;
				idx_q <= idx_q + 6'd1;
			end
			CMD_DONE: begin
				rsp_q.first_bad_index <= idx_q;
				rsp_q.all_passed <= idx_q == count_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (op_q) begin
			base_cnt = 4'd1;
		end else if (n_q < FULL_LIMIT) begin
			base_cnt = 4'd9;
		end else begin
			base_cnt = 4'd12;
		end
	end

	assign sts.n_even = !n_q[0];
	assign sts.n_is_one = n_q == 64'd1;
	assign sts.idx_done = idx_q == count_q;
	assign sts.sweep_last = i_q == 6'd63;
	assign sts.exp_more = k_q >= t_q;
	assign sts.exp_bit = nm1_q[k_q];
	assign sts.s_more = s_q < t_q;
	assign sts.a_is_one = a_q == one_q;
	assign sts.a_is_m1 = a_q == m1_q;
	assign sts.base_last = base_q == base_cnt - 4'd1;
	assign sts.mont_done = mont_done;
	assign rsp = rsp_q;
endmodule

@@ design/ppc_ctrl.sv @@
`timescale 1ns / 1ps
module ppc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  ppc_pkg::sts_t sts,
	output ppc_pkg::cmd_t cmd
);
	import ppc_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_CHK  = 5'd1;
	localparam logic [4:0] S_TERM = 5'd2;
	localparam logic [4:0] S_SWP  = 5'd3;
	localparam logic [4:0] S_SFIN = 5'd4;
	localparam logic [4:0] S_R2I  = 5'd5;
	localparam logic [4:0] S_DBLC = 5'd6;
	localparam logic [4:0] S_DBLA = 5'd7;
	localparam logic [4:0] S_R2ST = 5'd8;
	localparam logic [4:0] S_R2W  = 5'd9;
	localparam logic [4:0] S_BST  = 5'd10;
	localparam logic [4:0] S_BW   = 5'd11;
	localparam logic [4:0] S_EXPC = 5'd12;
	localparam logic [4:0] S_SQW  = 5'd13;
	localparam logic [4:0] S_MBST = 5'd14;
	localparam logic [4:0] S_MBW  = 5'd15;
	localparam logic [4:0] S_CHK1 = 5'd16;
	localparam logic [4:0] S_SCHK = 5'd17;
	localparam logic [4:0] S_SW   = 5'd18;
	localparam logic [4:0] S_STST = 5'd19;
	localparam logic [4:0] S_PASS = 5'd20;
	localparam logic [4:0] S_FIN  = 5'd21;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic [2:0] cnt_q;
	logic [2:0] cnt_d;
	logic       rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd.code = CMD_NOP;
		cmd.mont_start = 1'b0;
		cmd.msel = MS_R2SQ;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.code = CMD_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: state_d = sts.n_even ? S_FIN : S_TERM;
			S_TERM: begin
				if (sts.idx_done || sts.n_is_one) begin
					state_d = S_FIN;
				end else begin
					cmd.code = CMD_SW_START;
					state_d = S_SWP;
				end
			end
			S_SWP: begin
				cmd.code = CMD_SW_STEP;
				if (sts.sweep_last) begin
					state_d = S_SFIN;
				end
			end
			S_SFIN: begin
				cmd.code = CMD_SW_FIN;
				state_d = S_R2I;
			end
			S_R2I: begin
				cmd.code = CMD_R2_INIT;
				cnt_d = 3'd0;
				state_d = S_DBLC;
			end
			S_DBLC: begin
				cmd.code = CMD_DBL_CMP;
				state_d = S_DBLA;
			end
			S_DBLA: begin
				cmd.code = CMD_DBL_APPLY;
				if (cnt_q == 3'd1) begin
					cnt_d = 3'd0;
					state_d = S_R2ST;
				end else begin
					cnt_d = cnt_q + 3'd1;
					state_d = S_DBLC;
				end
			end
			S_R2ST: begin
				cmd.mont_start = 1'b1;
				cmd.msel = MS_R2SQ;
				state_d = S_R2W;
			end
			S_R2W: begin
				if (sts.mont_done) begin
					if (cnt_q == 3'd4) begin
						state_d = S_BST;
					end else begin
						cnt_d = cnt_q + 3'd1;
						state_d = S_R2ST;
					end
				end
			end
			S_BST: begin
				cmd.mont_start = 1'b1;
				cmd.msel = MS_BASE;
				state_d = S_BW;
			end
			S_BW: begin
				if (sts.mont_done) begin
					cmd.code = CMD_EXP_INIT;
					state_d = S_EXPC;
				end
			end
			S_EXPC: begin
				if (sts.exp_more) begin
					cmd.mont_start = 1'b1;
					cmd.msel = MS_ASQ;
					state_d = S_SQW;
				end else begin
					state_d = S_CHK1;
				end
			end
			S_SQW: begin
				if (sts.mont_done) begin
					if (sts.exp_bit) begin
						state_d = S_MBST;
					end else begin
						cmd.code = CMD_EXP_DEC;
						state_d = S_EXPC;
					end
				end
			end
			S_MBST: begin
				cmd.mont_start = 1'b1;
				cmd.msel = MS_AMB;
				state_d = S_MBW;
			end
			S_MBW: begin
				if (sts.mont_done) begin
					cmd.code = CMD_EXP_DEC;
					state_d = S_EXPC;
				end
			end
			S_CHK1: begin
				if (sts.a_is_one || sts.a_is_m1) begin
					state_d = S_PASS;
				end else begin
					cmd.code = CMD_S_INIT;
					state_d = S_SCHK;
				end
			end
			S_SCHK: begin
				if (sts.s_more) begin
					cmd.mont_start = 1'b1;
					cmd.msel = MS_ASQ;
					state_d = S_SW;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SW: begin
				if (sts.mont_done) begin
					state_d = S_STST;
				end
			end
			S_STST: begin
				if (sts.a_is_m1) begin
					state_d = S_PASS;
				end else begin
					cmd.code = CMD_S_INC;
					state_d = S_SCHK;
				end
			end
			S_PASS: begin
				if (sts.base_last) begin
					cmd.code = CMD_TERM_NEXT;
					state_d = S_TERM;
				end else begin
					cmd.code = CMD_NEXT_BASE;
					state_d = S_BST;
				end
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.code = CMD_DONE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= 3'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (cmd.code == CMD_DONE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
endmodule

@@ design/prime_progression_checker.sv @@
`timescale 1ns / 1ps
// Checks an arithmetic progression of odd 64-bit terms, spaced by difference times 223092870,
// with a strong probable prime test per term and base, and returns the index of the first
// failing term. One word is processed at a time; a finished result waits in an output
// register while the next word is accepted. Each term costs a setup sweep (modular
// inverse and R mod n, one bit per cycle) plus Montgomery products of 13 steps each,
// since one 32x32 multiplier builds every 64-bit product from partial products. A base
// test takes up to about 130 such products.
module prime_progression_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ppc_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ppc_pkg::rsp_t   rsp
);
	import ppc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ppc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.sts(sts),
		.cmd(cmd)
	);

	ppc_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req(req),
		.sts(sts),
		.rsp(rsp)
	);
endmodule
